[rtl/core/pfa_pkg.sv]
// Shared types and constants of the partition fit allocator.
// No dependencies; the interfaces, fit unit and allocator use this package.
`default_nettype none

package pfa_pkg;

  // Fixed field widths of the item channels and the configuration port.
  localparam int OPCODE_W   = 2;
  localparam int SLOT_W     = 4;
  localparam int AMOUNT_W   = 16;
  localparam int MODE_W     = 2;
  localparam int PIU_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Item opcodes; the fourth code is unused and changes nothing.
  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // Placement policies; the unused code behaves as first fit.
  typedef enum logic [MODE_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIT_MODE  = 1'd0,
    CFG_PARTS_USE = 1'd1
  } cfg_e;

  localparam logic [PIU_W-1:0] PIU_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  // Control from the sequencer to the shared fit unit.
  typedef struct packed {
    logic start;   // clear the running pick at item accept
    logic cmp_en;  // table entry data is present this cycle
    logic taken;   // that entry is already allocated
  } fit_ctl_t;

endpackage

`default_nettype wire

[rtl/core/pfa_req_if.sv]
// Request channel of the partition fit allocator: valid/ready plus the item.
// Depends on pfa_pkg for the field widths.
`default_nettype none

interface pfa_req_if;
  logic                          valid;
  logic                          ready;
  logic [pfa_pkg::OPCODE_W-1:0]  opcode;
  logic [pfa_pkg::SLOT_W-1:0]    slot;
  logic [pfa_pkg::AMOUNT_W-1:0]  amount;

  modport source (output valid, opcode, slot, amount, input ready);
  modport sink   (input valid, opcode, slot, amount, output ready);
endinterface

`default_nettype wire

[rtl/core/pfa_rsp_if.sv]
// Result channel of the partition fit allocator: valid/ready plus the item.
// Depends on pfa_pkg for the field widths.
`default_nettype none

interface pfa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          granted;
  logic [pfa_pkg::SLOT_W-1:0]    chosen_slot;
  logic [pfa_pkg::AMOUNT_W-1:0]  slot_total;
  logic [pfa_pkg::AMOUNT_W-1:0]  leftover;

  modport source (output valid, granted, chosen_slot, slot_total, leftover, input ready);
  modport sink   (input valid, granted, chosen_slot, slot_total, leftover, output ready);
endinterface

`default_nettype wire

[rtl/core/pfa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module pfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

`default_nettype wire

[rtl/core/pfa_fit_unit.sv]
// Shared compare unit: checks one table entry per cycle against the request
// and keeps the running pick. Depends on pfa_pkg.
`default_nettype none

module pfa_fit_unit import pfa_pkg::*; #(
  parameter int SIZE_BITS = 16,
  parameter int IDX_W     = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire fit_ctl_t             ctl_i,
  input  wire logic [MODE_W-1:0]    mode_i,
  input  wire logic [SIZE_BITS-1:0] amount_i,
  input  wire logic [IDX_W-1:0]     idx_i,
  input  wire logic [SIZE_BITS-1:0] size_i,
  output logic                      found_o,
  output logic [IDX_W-1:0]          pick_o,
  output logic [SIZE_BITS-1:0]      pick_size_o
);

  logic                 found_q;
  logic [IDX_W-1:0]     pick_q;
  logic [SIZE_BITS-1:0] pick_size_q;
  logic                 cand;
  logic                 take;

  assign cand = ctl_i.cmp_en && !ctl_i.taken && (size_i >= amount_i);

  // The first candidate is always taken; later ones replace it only under
  // best or worst fit, and only on a strict improvement so ties keep the
  // lower index.
  always_comb begin
    take = 1'b0;
    if (cand) begin
      if (!found_q) begin
        take = 1'b1;
      end else if (mode_i == FIT_BEST) begin
        take = size_i < pick_size_q;
      end else if (mode_i == FIT_WORST) begin
        take = size_i > pick_size_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.start) begin
      found_q <= 1'b0;
    end else if (cand) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !ctl_i.start) begin
      pick_q      <= idx_i;
      pick_size_q <= size_i;
    end
  end

  assign found_o     = found_q;
  assign pick_o      = pick_q;
  assign pick_size_o = pick_size_q;

endmodule

`default_nettype wire

[rtl/core/partition_fit_allocator.sv]
// Partition fit allocator: an allocate item scans the first N table entries,
// N being partitions in use capped at the table depth, with one shared
// comparator that checks one table entry per cycle. Load, clear and unknown
// items, and allocates with N zero, skip the scan; a stalled result keeps the
// block busy. Reset frees every partition and sets first fit with all 16
// partitions in use; partition sizes are undefined until loaded.
`default_nettype none

module partition_fit_allocator import pfa_pkg::*; #(
  parameter int NUM_PARTS = 16,
  parameter int SIZE_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  pfa_req_if.sink                    req,
  pfa_rsp_if.source                  rsp
);

  localparam int IDX_W = $clog2(NUM_PARTS);
  // Count width that holds both the table depth and any configured value.
  localparam int CNT_W = ($clog2(NUM_PARTS + 1) > PIU_W) ? $clog2(NUM_PARTS + 1) : PIU_W;

  // Configuration registers.
  logic [MODE_W-1:0] fit_mode_q;
  logic [PIU_W-1:0]  piu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q <= FIT_FIRST;
      piu_q      <= PIU_RESET;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_FIT_MODE:  fit_mode_q <= cfg_data_i[MODE_W-1:0];
        CFG_PARTS_USE: piu_q      <= cfg_data_i[PIU_W-1:0];
        default: ;
      endcase
    end
  end

  // The number of entries scanned saturates at the table depth.
  logic [CNT_W-1:0] limit_d;
  assign limit_d = (CNT_W'(piu_q) > CNT_W'(NUM_PARTS)) ? CNT_W'(NUM_PARTS) : CNT_W'(piu_q);

  state_e state_q, state_d;

  logic                 accept;
  logic                 in_ready;
  logic                 rd_issue;
  logic                 load_out;
  logic                 last_rd;
  logic [CNT_W-1:0]     limit_q;
  logic [IDX_W-1:0]     rd_idx_q;
  logic                 cmp_en_q;
  logic [IDX_W-1:0]     cmp_idx_q;
  logic [SIZE_BITS-1:0] amt_q;
  logic [NUM_PARTS-1:0] taken_q;
  logic                 slot_ok;
  logic                 ram_we;
  logic [SIZE_BITS-1:0] ram_rdata;
  logic                 fit_found;
  logic [IDX_W-1:0]     fit_pick;
  logic [SIZE_BITS-1:0] fit_pick_size;
  fit_ctl_t             fit_ctl;

  assign accept  = req.valid && in_ready;
  assign last_rd = (CNT_W'(rd_idx_q) + CNT_W'(1)) == limit_q;
  assign slot_ok = 32'(req.slot) < NUM_PARTS;

  // Next state: an allocate item with entries to scan walks the table, every
  // other item goes straight to the result stage. The result stage waits until
  // the output register is free, so the channel never loses an item.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if ((op_e'(req.opcode) == OP_ALLOC) && (limit_d != '0)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_SCAN: begin
        if (last_rd) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_d = ST_RESULT;
      ST_RESULT: begin
        if (!rsp.valid || rsp.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready = 1'b0;
    rd_issue = 1'b0;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready = 1'b1;
      ST_SCAN:   rd_issue = 1'b1;
      ST_DRAIN:  ;
      ST_RESULT: load_out = !rsp.valid || rsp.ready;
      default:   ;
    endcase
  end

  assign req.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_idx_q <= '0;
      cmp_en_q <= 1'b0;
      limit_q  <= '0;
    end else begin
      state_q  <= state_d;
      // Read data comes back in the cycle after the address, so the compare
      // enable and entry index trail the read by one stage.
      cmp_en_q <= rd_issue;
      if (accept) begin
        rd_idx_q <= '0;
        limit_q  <= limit_d;
      end else if (rd_issue) begin
        rd_idx_q <= rd_idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= rd_idx_q;
    if (accept) begin
      amt_q <= SIZE_BITS'(req.amount);
    end
  end

  // Taken marks live in flip-flops: a clear item frees all of them at once,
  // and a grant marks its partition as the result is registered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= '0;
    end else if (accept && (op_e'(req.opcode) == OP_CLEAR)) begin
      taken_q <= '0;
    end else if (load_out && fit_found) begin
      taken_q[fit_pick] <= 1'b1;
    end
  end

  // Loads write the size table directly at acceptance; a slot beyond the
  // table is dropped.
  assign ram_we = accept && (op_e'(req.opcode) == OP_LOAD) && slot_ok;

  pfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_PARTS)
  ) u_size_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (IDX_W'(req.slot)),
    .wr_data_i (SIZE_BITS'(req.amount)),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (ram_rdata)
  );

  assign fit_ctl.start  = accept;
  assign fit_ctl.cmp_en = cmp_en_q;
  assign fit_ctl.taken  = taken_q[cmp_idx_q];

  pfa_fit_unit #(
    .SIZE_BITS (SIZE_BITS),
    .IDX_W     (IDX_W)
  ) u_fit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (fit_ctl),
    .mode_i      (fit_mode_q),
    .amount_i    (amt_q),
    .idx_i       (cmp_idx_q),
    .size_i      (ram_rdata),
    .found_o     (fit_found),
    .pick_o      (fit_pick),
    .pick_size_o (fit_pick_size)
  );

  // Output register. Items other than a successful allocate report all zero,
  // which follows from the fit unit being cleared at every acceptance.
  logic                out_valid_q;
  logic                granted_q;
  logic [SLOT_W-1:0]   chosen_q;
  logic [AMOUNT_W-1:0] total_q;
  logic [AMOUNT_W-1:0] leftover_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      granted_q <= fit_found;
      if (fit_found) begin
        chosen_q   <= SLOT_W'(fit_pick);
        total_q    <= AMOUNT_W'(fit_pick_size);
        leftover_q <= AMOUNT_W'(fit_pick_size - amt_q);
      end else begin
        chosen_q   <= '0;
        total_q    <= '0;
        leftover_q <= '0;
      end
    end
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.granted     = granted_q;
  assign rsp.chosen_slot = chosen_q;
  assign rsp.slot_total  = total_q;
  assign rsp.leftover    = leftover_q;

  // A grant never lands on a partition that is already taken.
  a_grant_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && fit_found) |-> !taken_q[fit_pick])
    else $error("grant of a taken partition");

  // The scan never reads past the entries in use.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (CNT_W'(rd_idx_q) < limit_q))
    else $error("scan index beyond partitions in use");

  // One item at a time: the block drops ready after taking an item.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req.ready)
    else $error("second item accepted while busy");

endmodule

`default_nettype wire
